// ===== src/smt_rename_queue_dispatch_unit_assert.svh =====
// Assertion macros shared by the rename queue dispatch RTL.
`ifndef SMT_RENAME_QUEUE_DISPATCH_UNIT_ASSERT_SVH
`define SMT_RENAME_QUEUE_DISPATCH_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SMTRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smtrq assertion failed");
`define SMTRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smtrq assertion failed");
`else
`define SMTRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SMTRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/smtrq_pkg.sv =====
`timescale 1ns / 1ps
package smtrq_pkg;

    localparam int NUM_CONTEXTS_DEF = 4;
    localparam int FIFO_DEPTH_DEF   = 32;
    localparam int MAX_WIDTH_DEF    = 8;

    localparam int MASK_W   = 4;
    localparam int LIMIT_W  = 7;
    localparam int RW_W     = 4;
    localparam int ID_W     = 32;
    localparam int WT_W     = 4;
    localparam int OPN_W    = 3;
    localparam int CTXREQ_W = 2;
    localparam int KIND_W   = 2;
    localparam int SUM_W    = 6;
    localparam int SLOT_W   = 5;
    localparam int DIVS_W   = 4;
    localparam int CX_W     = 3;
    localparam int ADDR_W_CFG = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_DISPATCH = 2'd0,
        KIND_SUMMARY  = 2'd1,
        KIND_ACK      = 2'd2
    } kind_t;

    localparam logic CMD_ENQ  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] REG_RENAME_WIDTH = 2'd0;
    localparam logic [1:0] REG_QUEUE_LIMIT  = 2'd1;
    localparam logic [1:0] REG_ACTIVE_MASK  = 2'd2;
    localparam logic [1:0] REG_IDEAL_MASK   = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [WT_W-1:0]  wt;
        logic             fp;
        logic [OPN_W-1:0] dests;
        logic [OPN_W-1:0] srcs;
    } rec_t;

    typedef struct packed {
        logic               start;
        logic [LIMIT_W-1:0] dividend;
        logic [DIVS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [LIMIT_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic mask_bit(input logic [MASK_W-1:0] m, input logic [CX_W-1:0] c);
        return (c < CX_W'(MASK_W)) && m[c[1:0]];
    endfunction

endpackage

// ===== src/smtrq_div.sv =====
`timescale 1ns / 1ps
module smtrq_div (
    input  logic               clk,
    input  logic               rst_n,
    input  smtrq_pkg::div_req_t req,
    output smtrq_pkg::div_rsp_t rsp
);
    import smtrq_pkg::*;

    localparam int STEP_W = $clog2(LIMIT_W);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [DIVS_W-1:0]   rem_reg;
    logic [LIMIT_W-1:0]  quo_reg;
    logic [DIVS_W-1:0]   dvs_reg;
    logic [DIVS_W:0]     trial;
    logic [DIVS_W:0]     diff;
    logic                ge;
    logic [DIVS_W-1:0]   rem_next;
    logic [LIMIT_W-1:0]  quo_next;

    // One restoring division step per cycle, most significant quotient bit first.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[LIMIT_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
        quo_next = {quo_reg[LIMIT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if (step_reg == STEP_W'(LIMIT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== src/smt_rename_queue_dispatch_unit.sv =====
`timescale 1ns / 1ps
// Multithreaded rename queue with round-robin dispatch. Each hardware context
// owns a FIFO of decoded instruction records held in one shared memory. An
// enqueue beat stores a record (or reports overflow) in the S_ENQ state, which
// registers its acknowledge beat for the output. A tick beat scans the
// contexts one per cycle and, if none is active and unstalled, returns a
// blocked summary beat. Otherwise it dispatches from the chosen context one
// instruction at a time (memory read, check, output beat), then counts the
// non-ideal contexts, runs the share division and builds the stall mask (both
// skipped when no context is non-ideal) and returns the summary beat. The
// input is not ready while an item is in progress, and every output beat
// waits for out_ready before the sequencer moves on.
`include "smt_rename_queue_dispatch_unit_assert.svh"
module smt_rename_queue_dispatch_unit #(
    parameter int NUM_CONTEXTS = smtrq_pkg::NUM_CONTEXTS_DEF,
    parameter int FIFO_DEPTH   = smtrq_pkg::FIFO_DEPTH_DEF,
    parameter int MAX_WIDTH    = smtrq_pkg::MAX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [smtrq_pkg::ADDR_W_CFG-1:0]    paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic [smtrq_pkg::CTXREQ_W-1:0]      context_req,
    input  logic [smtrq_pkg::ID_W-1:0]          inst_id,
    input  logic [smtrq_pkg::WT_W-1:0]          weight,
    input  logic                                is_float,
    input  logic [smtrq_pkg::OPN_W-1:0]         num_dests,
    input  logic [smtrq_pkg::OPN_W-1:0]         num_sources,
    input  logic [smtrq_pkg::MASK_W-1:0]        downstream_stall,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [smtrq_pkg::KIND_W-1:0]        kind,
    output logic [smtrq_pkg::ID_W-1:0]          out_inst_id,
    output logic [smtrq_pkg::CTXREQ_W-1:0]      chosen_context,
    output logic [smtrq_pkg::MASK_W-1:0]        stall_mask,
    output logic                                blocked,
    output logic [smtrq_pkg::RW_W-1:0]          renamed_slots,
    output logic [smtrq_pkg::SUM_W-1:0]         int_dests,
    output logic [smtrq_pkg::SUM_W-1:0]         fp_dests,
    output logic [smtrq_pkg::SUM_W-1:0]         int_lookups,
    output logic [smtrq_pkg::SUM_W-1:0]         fp_lookups,
    output logic                                overflow,
    output logic                                last
);
    import smtrq_pkg::*;

    localparam int CTX_W     = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_CONTEXTS * FIFO_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int TOT_W     = $clog2(MEM_DEPTH + 1);
    localparam int CMP_W     = ((TOT_W > LIMIT_W) ? TOT_W : LIMIT_W) + 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_ENQ   = 10'b0000000010,
        S_SCAN  = 10'b0000000100,
        S_READ  = 10'b0000001000,
        S_CHECK = 10'b0000010000,
        S_STAT  = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_MASK  = 10'b0010000000,
        S_SUM   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    typedef struct packed {
        kind_t               kind;
        logic [ID_W-1:0]     id;
        logic [CTXREQ_W-1:0] ctx;
        logic [MASK_W-1:0]   mask;
        logic                blocked;
        logic [RW_W-1:0]     slots;
        logic [SUM_W-1:0]    idst;
        logic [SUM_W-1:0]    fdst;
        logic [SUM_W-1:0]    ilk;
        logic [SUM_W-1:0]    flk;
        logic                ovf;
        logic                last;
    } res_t;

    rec_t               mem [MEM_DEPTH];

    logic [RW_W-1:0]    rename_width_reg;
    logic [LIMIT_W-1:0] queue_limit_reg;
    logic [MASK_W-1:0]  active_mask_reg;
    logic [MASK_W-1:0]  ideal_mask_reg;

    state_t             state_reg;
    logic [CTX_W-1:0]   cur_ctx_reg;
    logic [CTX_W-1:0]   step_reg;
    logic [CTX_W-1:0]   last_served_reg;
    logic               enq_ok_reg;
    rec_t               enq_rec_reg;
    rec_t               rd_rec_reg;
    logic [MASK_W-1:0]  stall_reg;
    logic [PTR_W-1:0]   head_reg  [NUM_CONTEXTS];
    logic [CNT_W-1:0]   count_reg [NUM_CONTEXTS];
    logic [SLOT_W-1:0]  slots_reg;
    logic [SUM_W-1:0]   idst_reg;
    logic [SUM_W-1:0]   fdst_reg;
    logic [SUM_W-1:0]   ilk_reg;
    logic [SUM_W-1:0]   flk_reg;
    logic [DIVS_W-1:0]  nonideal_reg;
    logic [TOT_W-1:0]   total_reg;
    logic [LIMIT_W-1:0] share_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic               out_valid_reg;
    res_t               out_reg;

    logic               cfg_write;
    logic [SLOT_W-1:0]  width_eff;
    logic [CX_W-1:0]    cur_ext;
    logic               cur_active;
    logic               cur_ideal;
    logic               cur_stall;
    logic               cur_last;
    logic [CTX_W-1:0]   cur_inc;
    logic [PTR_W-1:0]   cur_head;
    logic [CNT_W-1:0]   cur_count;
    logic [PTR_W:0]     pos_sum;
    logic [PTR_W-1:0]   tail_pos;
    logic [ADDR_W-1:0]  ctx_base;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [SLOT_W:0]    slots_try;
    logic               fits;
    logic               counted;
    logic [DIVS_W-1:0]  nonideal_add;
    logic [TOT_W-1:0]   total_add;
    logic               over_share;
    logic               over_total;
    res_t               ack_res;
    res_t               disp_res;
    res_t               sum_res;
    res_t               blk_res;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_RENAME_WIDTH: prdata = 32'(rename_width_reg);
            REG_QUEUE_LIMIT:  prdata = 32'(queue_limit_reg);
            REG_ACTIVE_MASK:  prdata = 32'(active_mask_reg);
            REG_IDEAL_MASK:   prdata = 32'(ideal_mask_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rename_width_reg <= RW_W'(4);
            queue_limit_reg  <= LIMIT_W'(32);
            active_mask_reg  <= '0;
            ideal_mask_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_RENAME_WIDTH: rename_width_reg <= pwdata[RW_W-1:0];
                REG_QUEUE_LIMIT:  queue_limit_reg  <= pwdata[LIMIT_W-1:0];
                REG_ACTIVE_MASK:  active_mask_reg  <= pwdata[MASK_W-1:0];
                REG_IDEAL_MASK:   ideal_mask_reg   <= pwdata[MASK_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        width_eff  = ({1'b0, rename_width_reg} > SLOT_W'(MAX_WIDTH)) ?
                     SLOT_W'(MAX_WIDTH) : {1'b0, rename_width_reg};
        cur_ext    = CX_W'(cur_ctx_reg);
        cur_active = mask_bit(active_mask_reg, cur_ext);
        cur_ideal  = mask_bit(ideal_mask_reg, cur_ext);
        cur_stall  = mask_bit(stall_reg, cur_ext);
        cur_last   = cur_ctx_reg == CTX_W'(NUM_CONTEXTS - 1);
        cur_inc    = cur_last ? '0 : cur_ctx_reg + 1'b1;
        cur_head   = head_reg[cur_ctx_reg];
        cur_count  = count_reg[cur_ctx_reg];
        pos_sum    = {1'b0, cur_head} + (PTR_W + 1)'(cur_count);
        tail_pos   = (pos_sum >= (PTR_W + 1)'(FIFO_DEPTH)) ?
                     PTR_W'(pos_sum - (PTR_W + 1)'(FIFO_DEPTH)) : pos_sum[PTR_W-1:0];
        ctx_base   = ADDR_W'(cur_ctx_reg) * ADDR_W'(FIFO_DEPTH);
        wr_addr    = ctx_base + ADDR_W'(tail_pos);
        rd_addr    = ctx_base + ADDR_W'(cur_head);
        slots_try  = {1'b0, slots_reg} + (SLOT_W + 1)'(rd_rec_reg.wt);
        fits       = slots_try <= (SLOT_W + 1)'(width_eff);
        counted    = cur_active && !cur_ideal;
        nonideal_add = nonideal_reg + DIVS_W'(counted);
        total_add  = total_reg + (counted ? TOT_W'(cur_count) : '0);
        over_share = CMP_W'(cur_count) >= CMP_W'(share_reg);
        over_total = CMP_W'(total_reg) >= CMP_W'(queue_limit_reg);
    end

    always_comb
    begin
        ack_res       = '0;
        ack_res.kind  = KIND_ACK;
        ack_res.ovf   = enq_ok_reg && (cur_count >= CNT_W'(FIFO_DEPTH));
        ack_res.last  = 1'b1;

        disp_res      = '0;
        disp_res.kind = KIND_DISPATCH;
        disp_res.id   = rd_rec_reg.id;
        disp_res.ctx  = CTXREQ_W'(cur_ctx_reg);

        sum_res       = '0;
        sum_res.kind  = KIND_SUMMARY;
        sum_res.ctx   = CTXREQ_W'(last_served_reg);
        sum_res.mask  = mask_reg;
        sum_res.slots = slots_reg[RW_W-1:0];
        sum_res.idst  = idst_reg;
        sum_res.fdst  = fdst_reg;
        sum_res.ilk   = ilk_reg;
        sum_res.flk   = flk_reg;
        sum_res.last  = 1'b1;

        blk_res         = '0;
        blk_res.kind    = KIND_SUMMARY;
        blk_res.mask    = stall_reg;
        blk_res.blocked = 1'b1;
        blk_res.last    = 1'b1;
    end

    always_comb
    begin
        div_req.start    = (state_reg == S_STAT) && cur_last && (nonideal_add != '0);
        div_req.dividend = queue_limit_reg;
        div_req.divisor  = nonideal_add;
    end

    smtrq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ENQ && enq_ok_reg && cur_count < CNT_W'(FIFO_DEPTH))
        begin
            mem[wr_addr] <= enq_rec_reg;
        end
        if (state_reg == S_READ)
        begin
            rd_rec_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cur_ctx_reg     <= '0;
            step_reg        <= '0;
            last_served_reg <= '0;
            enq_ok_reg      <= 1'b0;
            enq_rec_reg     <= '0;
            stall_reg       <= '0;
            for (int i = 0; i < NUM_CONTEXTS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            slots_reg       <= '0;
            idst_reg        <= '0;
            fdst_reg        <= '0;
            ilk_reg         <= '0;
            flk_reg         <= '0;
            nonideal_reg    <= '0;
            total_reg       <= '0;
            share_reg       <= '0;
            mask_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        stall_reg <= downstream_stall;
                        if (cmd == CMD_ENQ)
                        begin
                            enq_ok_reg        <= 32'(context_req) < NUM_CONTEXTS;
                            cur_ctx_reg       <= CTX_W'(context_req);
                            enq_rec_reg.id    <= inst_id;
                            enq_rec_reg.wt    <= (weight == '0) ? WT_W'(1) : weight;
                            enq_rec_reg.fp    <= is_float;
                            enq_rec_reg.dests <= num_dests;
                            enq_rec_reg.srcs  <= num_sources;
                            state_reg         <= S_ENQ;
                        end
                        else
                        begin
                            cur_ctx_reg <= (last_served_reg == CTX_W'(NUM_CONTEXTS - 1)) ?
                                           '0 : last_served_reg + 1'b1;
                            step_reg    <= '0;
                            state_reg   <= S_SCAN;
                        end
                    end
                end
                S_ENQ:
                begin
                    if (enq_ok_reg && cur_count < CNT_W'(FIFO_DEPTH))
                    begin
                        count_reg[cur_ctx_reg] <= cur_count + 1'b1;
                    end
                    out_reg       <= ack_res;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_SCAN:
                begin
                    if (cur_active && !cur_stall)
                    begin
                        last_served_reg <= cur_ctx_reg;
                        slots_reg       <= '0;
                        idst_reg        <= '0;
                        fdst_reg        <= '0;
                        ilk_reg         <= '0;
                        flk_reg         <= '0;
                        state_reg       <= S_READ;
                    end
                    else if (step_reg == CTX_W'(NUM_CONTEXTS - 1))
                    begin
                        out_reg       <= blk_res;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        cur_ctx_reg <= cur_inc;
                        step_reg    <= step_reg + 1'b1;
                    end
                end
                S_READ:
                begin
                    if (slots_reg < width_eff && cur_count != '0)
                    begin
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        cur_ctx_reg  <= '0;
                        nonideal_reg <= '0;
                        total_reg    <= '0;
                        state_reg    <= S_STAT;
                    end
                end
                S_CHECK:
                begin
                    if (fits)
                    begin
                        slots_reg <= slots_try[SLOT_W-1:0];
                        if (rd_rec_reg.fp)
                        begin
                            fdst_reg <= fdst_reg + SUM_W'(rd_rec_reg.dests);
                            flk_reg  <= flk_reg + SUM_W'(rd_rec_reg.srcs);
                        end
                        else
                        begin
                            idst_reg <= idst_reg + SUM_W'(rd_rec_reg.dests);
                            ilk_reg  <= ilk_reg + SUM_W'(rd_rec_reg.srcs);
                        end
                        head_reg[cur_ctx_reg]  <= (cur_head == PTR_W'(FIFO_DEPTH - 1)) ?
                                                  '0 : cur_head + 1'b1;
                        count_reg[cur_ctx_reg] <= cur_count - 1'b1;
                        out_reg       <= disp_res;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        cur_ctx_reg  <= '0;
                        nonideal_reg <= '0;
                        total_reg    <= '0;
                        state_reg    <= S_STAT;
                    end
                end
                S_STAT:
                begin
                    nonideal_reg <= nonideal_add;
                    total_reg    <= total_add;
                    mask_reg     <= '0;
                    if (cur_last)
                    begin
                        state_reg <= (nonideal_add == '0) ? S_SUM : S_DIV;
                    end
                    else
                    begin
                        cur_ctx_reg <= cur_inc;
                    end
                end
                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        share_reg   <= div_rsp.quotient;
                        cur_ctx_reg <= '0;
                        state_reg   <= S_MASK;
                    end
                end
                S_MASK:
                begin
                    if (counted && (over_share || over_total))
                    begin
                        mask_reg[cur_ext[1:0]] <= 1'b1;
                    end
                    if (cur_last)
                    begin
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        cur_ctx_reg <= cur_inc;
                    end
                end
                S_SUM:
                begin
                    out_reg       <= sum_res;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        cur_ctx_reg   <= out_reg.last ? cur_ctx_reg : last_served_reg;
                        state_reg     <= out_reg.last ? S_IDLE : S_READ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready       = state_reg == S_IDLE;
    assign out_valid      = out_valid_reg;
    assign kind           = out_reg.kind;
    assign out_inst_id    = out_reg.id;
    assign chosen_context = out_reg.ctx;
    assign stall_mask     = out_reg.mask;
    assign blocked        = out_reg.blocked;
    assign renamed_slots  = out_reg.slots;
    assign int_dests      = out_reg.idst;
    assign fp_dests       = out_reg.fdst;
    assign int_lookups    = out_reg.ilk;
    assign fp_lookups     = out_reg.flk;
    assign overflow       = out_reg.ovf;
    assign last           = out_reg.last;

    `SMTRQ_ASSERT_IMP(a_ready_excl, clk, rst_n, in_ready, !out_valid)
    `SMTRQ_ASSERT_NXT(a_disp_resume, clk, rst_n, out_valid && out_ready && !last, state_reg == S_READ)
    `SMTRQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg[cur_ctx_reg] <= CNT_W'(FIFO_DEPTH))

endmodule

// ===== tb/rename_dispatch_checker.sv =====
`timescale 1ns / 1ps
module rename_dispatch_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [smtrq_pkg::ADDR_W_CFG-1:0] paddr,
    input  logic [31:0]                     pwdata,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            cmd,
    input  logic [smtrq_pkg::CTXREQ_W-1:0]  context_req,
    input  logic [smtrq_pkg::ID_W-1:0]      inst_id,
    input  logic [smtrq_pkg::WT_W-1:0]      weight,
    input  logic                            is_float,
    input  logic [smtrq_pkg::OPN_W-1:0]     num_dests,
    input  logic [smtrq_pkg::OPN_W-1:0]     num_sources,
    input  logic [smtrq_pkg::MASK_W-1:0]    downstream_stall,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [smtrq_pkg::KIND_W-1:0]    kind,
    input  logic [smtrq_pkg::ID_W-1:0]      out_inst_id,
    input  logic [smtrq_pkg::CTXREQ_W-1:0]  chosen_context,
    input  logic [smtrq_pkg::MASK_W-1:0]    stall_mask,
    input  logic                            blocked,
    input  logic [smtrq_pkg::RW_W-1:0]      renamed_slots,
    input  logic [smtrq_pkg::SUM_W-1:0]     int_dests,
    input  logic [smtrq_pkg::SUM_W-1:0]     fp_dests,
    input  logic [smtrq_pkg::SUM_W-1:0]     int_lookups,
    input  logic [smtrq_pkg::SUM_W-1:0]     fp_lookups,
    input  logic                            overflow,
    input  logic                            last,
    output int                              fail_count,
    output int                              pending_count
);
    import smtrq_pkg::*;

    localparam int NCTX  = NUM_CONTEXTS_DEF;
    localparam int DEPTH = FIFO_DEPTH_DEF;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ID_W-1:0]     id;
        logic [CTXREQ_W-1:0] ctx;
        logic [MASK_W-1:0]   mask;
        logic                blk;
        logic [RW_W-1:0]     slots;
        logic [SUM_W-1:0]    idst;
        logic [SUM_W-1:0]    fdst;
        logic [SUM_W-1:0]    ilk;
        logic [SUM_W-1:0]    flk;
        logic                ovf;
        logic                lst;
    } beat_t;

    rec_t        rename_fifo [NCTX][DEPTH];
    int          fifo_head [NCTX];
    int          fifo_count [NCTX];
    int          last_ctx;
    int          width_reg;
    int          limit_reg;
    logic [3:0]  active_reg;
    logic [3:0]  ideal_reg;
    beat_t       expected_beats [$];

    assign pending_count = expected_beats.size();

    function automatic beat_t blank_beat(input kind_t k);
        beat_t b;
        b = '0;
        b.kind = k;
        return b;
    endfunction

    task automatic expect_beat(input beat_t b);
        expected_beats.insert(expected_beats.size(), b);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic predict_item();
        beat_t b;
        rec_t r;
        int c, w, chosen, slots, nonideal, total, share, pos;
        logic found;
        logic [3:0] m;
        if (cmd == CMD_ENQ) begin
            b = blank_beat(KIND_ACK);
            b.lst = 1'b1;
            c = int'(context_req);
            if (fifo_count[c] >= DEPTH) begin
                b.ovf = 1'b1;
            end
            else begin
                pos = (fifo_head[c] + fifo_count[c]) % DEPTH;
                r.id = inst_id;
                r.wt = (weight == 0) ? WT_W'(1) : weight;
                r.fp = is_float;
                r.dests = num_dests;
                r.srcs = num_sources;
                rename_fifo[c][pos] = r;
                fifo_count[c]++;
            end
            expect_beat(b);
        end
        else begin
            w = (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
            found = 1'b0;
            chosen = 0;
            for (int off = 1; off <= NCTX; off++) begin
                c = (last_ctx + off) % NCTX;
                if (!found && active_reg[c] && !downstream_stall[c]) begin
                    chosen = c;
                    found = 1'b1;
                end
            end
            if (!found) begin
                b = blank_beat(KIND_SUMMARY);
                b.mask = downstream_stall;
                b.blk = 1'b1;
                b.lst = 1'b1;
                expect_beat(b);
            end
            else begin
                beat_t s;
                s = blank_beat(KIND_SUMMARY);
                last_ctx = chosen;
                slots = 0;
                while (slots < w && fifo_count[chosen] > 0) begin
                    r = rename_fifo[chosen][fifo_head[chosen]];
                    if (slots + r.wt > w) break;
                    b = blank_beat(KIND_DISPATCH);
                    b.id = r.id;
                    b.ctx = CTXREQ_W'(chosen);
                    expect_beat(b);
                    slots += r.wt;
                    if (r.fp) begin
                        s.fdst += r.dests;
                        s.flk += r.srcs;
                    end
                    else begin
                        s.idst += r.dests;
                        s.ilk += r.srcs;
                    end
                    fifo_head[chosen] = (fifo_head[chosen] + 1) % DEPTH;
                    fifo_count[chosen]--;
                end
                nonideal = 0;
                total = 0;
                m = '0;
                for (int k = 0; k < NCTX; k++) begin
                    if (active_reg[k] && !ideal_reg[k]) begin
                        nonideal++;
                        total += fifo_count[k];
                    end
                end
                if (nonideal != 0) begin
                    share = limit_reg / nonideal;
                    for (int k = 0; k < NCTX; k++) begin
                        if (active_reg[k] && !ideal_reg[k]
                            && (fifo_count[k] >= share || total >= limit_reg))
                            m[k] = 1'b1;
                    end
                end
                s.ctx = CTXREQ_W'(chosen);
                s.mask = m;
                s.slots = RW_W'(slots);
                s.lst = 1'b1;
                expect_beat(s);
            end
        end
    endtask

    task automatic compare_beat();
        beat_t e;
        if (expected_beats.size() == 0) begin
            $display("unexpected beat kind %0d at %0t", kind, $realtime);
            fail_count++;
            return;
        end
        e = expected_beats.pop_front();
        if (kind !== e.kind) report_mismatch("kind", kind, e.kind);
        if (out_inst_id !== e.id) report_mismatch("out_inst_id", out_inst_id, e.id);
        if (chosen_context !== e.ctx) report_mismatch("chosen_context", chosen_context, e.ctx);
        if (stall_mask !== e.mask) report_mismatch("stall_mask", stall_mask, e.mask);
        if (blocked !== e.blk) report_mismatch("blocked", blocked, e.blk);
        if (renamed_slots !== e.slots) report_mismatch("renamed_slots", renamed_slots, e.slots);
        if (int_dests !== e.idst) report_mismatch("int_dests", int_dests, e.idst);
        if (fp_dests !== e.fdst) report_mismatch("fp_dests", fp_dests, e.fdst);
        if (int_lookups !== e.ilk) report_mismatch("int_lookups", int_lookups, e.ilk);
        if (fp_lookups !== e.flk) report_mismatch("fp_lookups", fp_lookups, e.flk);
        if (overflow !== e.ovf) report_mismatch("overflow", overflow, e.ovf);
        if (last !== e.lst) report_mismatch("last", last, e.lst);
    endtask

    initial begin
        fail_count = 0;
        last_ctx = 0;
        width_reg = 4;
        limit_reg = 32;
        active_reg = '0;
        ideal_reg = '0;
        for (int k = 0; k < NCTX; k++) begin
            fifo_head[k] = 0;
            fifo_count[k] = 0;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_RENAME_WIDTH: width_reg = int'(pwdata[3:0]);
                    REG_QUEUE_LIMIT:  limit_reg = int'(pwdata[6:0]);
                    REG_ACTIVE_MASK:  active_reg = pwdata[3:0];
                    REG_IDEAL_MASK:   ideal_reg = pwdata[3:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) compare_beat();
            if (in_valid && in_ready) predict_item();
        end
    end
endmodule

// ===== tb/tb_smt_rename_queue_dispatch_unit.sv =====
`timescale 1ns / 1ps
module tb_smt_rename_queue_dispatch_unit;
    import smtrq_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W_CFG-1:0] paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 cmd = CMD_ENQ;
    logic [CTXREQ_W-1:0]  context_req = '0;
    logic [ID_W-1:0]      inst_id = '0;
    logic [WT_W-1:0]      weight = '0;
    logic                 is_float = 1'b0;
    logic [OPN_W-1:0]     num_dests = '0;
    logic [OPN_W-1:0]     num_sources = '0;
    logic [MASK_W-1:0]    downstream_stall = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [KIND_W-1:0]    kind;
    logic [ID_W-1:0]      out_inst_id;
    logic [CTXREQ_W-1:0]  chosen_context;
    logic [MASK_W-1:0]    stall_mask;
    logic                 blocked;
    logic [RW_W-1:0]      renamed_slots;
    logic [SUM_W-1:0]     int_dests;
    logic [SUM_W-1:0]     fp_dests;
    logic [SUM_W-1:0]     int_lookups;
    logic [SUM_W-1:0]     fp_lookups;
    logic                 overflow;
    logic                 last;
    int                   fail_count;
    int                   pending_count;
    int                   sent_items = 0;
    logic                 calm_phase = 1'b0;
    logic                 hold_sink = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    smt_rename_queue_dispatch_unit dut (.*);

    rename_dispatch_checker checker_i (.*);

    always @(posedge clk) begin
        if (hold_sink) out_ready <= 1'b0;
        else if (calm_phase) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(99) >= 24);
    end

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W_CFG'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic send_item(input logic c, input logic [1:0] ctx, input logic [31:0] id,
                             input logic [3:0] wt, input logic fp, input logic [2:0] nd,
                             input logic [2:0] ns, input logic [3:0] st);
        if (!calm_phase) begin
            while ($urandom_range(99) < 24) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        cmd <= c;
        context_req <= ctx;
        inst_id <= id;
        weight <= wt;
        is_float <= fp;
        num_dests <= nd;
        num_sources <= ns;
        downstream_stall <= st;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_items++;
    endtask

    task automatic send_enqueue(input logic [1:0] ctx);
        send_item(CMD_ENQ, ctx, $urandom, 4'($urandom_range(8)), 1'($urandom),
                  3'($urandom), 3'($urandom), 4'($urandom));
    endtask

    task automatic send_tick(input logic [3:0] st);
        send_item(CMD_TICK, 2'($urandom), $urandom, 4'($urandom), 1'($urandom),
                  3'($urandom), 3'($urandom), st);
    endtask

    initial begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick(4'h0);
        drain();
        write_reg(REG_ACTIVE_MASK, 15);
        write_reg(REG_IDEAL_MASK, 0);
        write_reg(REG_RENAME_WIDTH, 8);
        write_reg(REG_QUEUE_LIMIT, 64);
        send_item(CMD_ENQ, 2'd0, 32'hFFFF_FFFF, 4'd8, 1'b1, 3'd7, 3'd7, 4'hF);
        send_item(CMD_ENQ, 2'd0, 32'h0, 4'd0, 1'b0, 3'd7, 3'd7, 4'h0);
        send_item(CMD_ENQ, 2'd1, 32'h1234_5678, 4'd15, 1'b0, 3'd0, 3'd0, 4'h0);
        send_item(CMD_ENQ, 2'd1, 32'hA5A5_A5A5, 4'd1, 1'b1, 3'd5, 3'd2, 4'h0);
        send_tick(4'h0);
        send_tick(4'hE);
        send_tick(4'hF);
        send_tick(4'h0);
        send_tick(4'h0);
        for (int k = 0; k < 33; k++)
            send_item(CMD_ENQ, 2'd3, $urandom, 4'd1, 1'($urandom), 3'($urandom),
                      3'($urandom), 4'h0);
        send_tick(4'h7);
        drain();
        write_reg(REG_RENAME_WIDTH, 0);
        write_reg(REG_QUEUE_LIMIT, 1);
        write_reg(REG_IDEAL_MASK, 4'hA);
        send_tick(4'h0);
        drain();
        write_reg(REG_RENAME_WIDTH, 15);
        write_reg(REG_QUEUE_LIMIT, 127);
        write_reg(REG_IDEAL_MASK, 4'hF);
        send_tick(4'h0);
        send_tick(4'h0);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            write_reg(REG_RENAME_WIDTH, (phase == 4) ? 1 : $urandom_range(1, 8));
            write_reg(REG_QUEUE_LIMIT, (phase == 1) ? 64 : $urandom_range(1, 64));
            write_reg(REG_ACTIVE_MASK, (phase == 0) ? 15 : $urandom_range(1, 15));
            write_reg(REG_IDEAL_MASK, $urandom_range(0, 15));
            calm_phase <= (phase == 2);
            if (phase == 3) begin
                fork
                    begin
                        hold_sink <= 1'b1;
                        repeat (300) @(posedge clk);
                        hold_sink <= 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 25; k++) begin
                if ($urandom_range(99) < 60) send_enqueue(2'($urandom));
                else send_tick(($urandom_range(99) < 60) ? 4'h0 : 4'($urandom));
            end
            drain();
        end
        calm_phase <= 1'b0;

        drain();
        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end
        else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/smtrq_pkg.sv
src/smtrq_div.sv
src/smt_rename_queue_dispatch_unit.sv
tb/rename_dispatch_checker.sv
tb/tb_smt_rename_queue_dispatch_unit.sv
